// File: src/utf8_stream_validator_defines.svh
// ---------------------------------------------------------------------------
// utf8 stream validator assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UTF8SV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define UTF8SV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/utf8sv_pkg.sv
// ---------------------------------------------------------------------------
// utf8sv_pkg
// types and constants shared by the utf8 stream validator
// ---------------------------------------------------------------------------
package utf8sv_pkg;

  localparam int unsigned CP_W = 21;

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_t;

  typedef struct packed {
    logic [1:0]      pending;
    seq_t            seq_len;
    logic [CP_W-1:0] acc;
    logic            err;
  } state_t;

  localparam state_t STATE_RESET = '{pending: 2'd0, seq_len: SEQ_NONE,
                                     acc: '0, err: 1'b0};

  localparam logic [7:0]      ASCII_LOW = 8'h20;
  localparam logic [7:0]      ASCII_DEL = 8'h7F;
  localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;

endpackage

// File: src/utf8_stream_validator.sv
// ---------------------------------------------------------------------------
// utf8_stream_validator
// checks byte strings for well-formed printable utf8, one verdict per string
// ---------------------------------------------------------------------------
// channel  dir  tdata          tlast      note
// s_*      in   [7:0] byte     last byte  one transfer per byte
// m_*      out  [0] verdict    -          one transfer per string
//
// one byte per cycle unless the input side stalls; after the transfer of the last
// byte a verdict passes the input register and then the result register
// synchronous reset clears the input register valid, sequence state and result valid
// the input side stalls only while a verdict is held and the next last byte
// waits in the input register
// ---------------------------------------------------------------------------
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] text_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata   // [0] string_valid, [7:1] zero
);

  logic               in_v;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               advance;
  logic               out_free;
  logic               verdict;
  logic               result;
  utf8sv_pkg::state_t st;
  utf8sv_pkg::state_t st_next;

  assign advance  = in_v && (!in_last || out_free);
  assign s_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  utf8sv_step u_step (
    .st        (st),
    .text_byte (in_byte),
    .st_next   (st_next),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= utf8sv_pkg::STATE_RESET;
    end else if (advance) begin
      st <= in_last ? utf8sv_pkg::STATE_RESET : st_next;
    end
  end

  utf8sv_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_last),
    .verdict  (verdict),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tdata = {7'd0, result};

endmodule

// File: src/utf8sv_step.sv
// ---------------------------------------------------------------------------
// utf8sv_step
// decodes one byte against the current sequence state
// ---------------------------------------------------------------------------
module utf8sv_step (
  input  utf8sv_pkg::state_t st,
  input  logic [7:0]         text_byte,
  output utf8sv_pkg::state_t st_next,
  output logic               verdict
);

  logic [utf8sv_pkg::CP_W-1:0] cp;
  logic                        cp_bad;

  assign cp = {st.acc[utf8sv_pkg::CP_W-7:0], text_byte[5:0]};

  always_comb begin
    cp_bad = 1'b0;
    unique case (st.seq_len)
      utf8sv_pkg::SEQ_TWO:   if (cp < utf8sv_pkg::MIN_TWO) cp_bad = 1'b1;
      utf8sv_pkg::SEQ_THREE: if (cp < utf8sv_pkg::MIN_THREE) cp_bad = 1'b1;
      utf8sv_pkg::SEQ_FOUR:  if (cp < utf8sv_pkg::MIN_FOUR) cp_bad = 1'b1;
      utf8sv_pkg::SEQ_NONE:  cp_bad = 1'b0;
    endcase
    if (cp > utf8sv_pkg::CP_MAX) cp_bad = 1'b1;
    if (cp >= utf8sv_pkg::SURR_LO && cp <= utf8sv_pkg::SURR_HI) cp_bad = 1'b1;
  end

  always_comb begin
    st_next = st;
    if (st.pending == 2'd0) begin
      priority if (text_byte < utf8sv_pkg::ASCII_LOW || text_byte == utf8sv_pkg::ASCII_DEL) begin
        st_next.err = 1'b1;
      end else if (!text_byte[7]) begin
        st_next.err = st.err;
      end else if (text_byte[7:5] == 3'b110) begin
        st_next.pending = 2'd1;
        st_next.seq_len = utf8sv_pkg::SEQ_TWO;
        st_next.acc     = {16'd0, text_byte[4:0]};
      end else if (text_byte[7:4] == 4'b1110) begin
        st_next.pending = 2'd2;
        st_next.seq_len = utf8sv_pkg::SEQ_THREE;
        st_next.acc     = {17'd0, text_byte[3:0]};
      end else if (text_byte[7:3] == 5'b11110) begin
        st_next.pending = 2'd3;
        st_next.seq_len = utf8sv_pkg::SEQ_FOUR;
        st_next.acc     = {18'd0, text_byte[2:0]};
      end else begin
        st_next.err = 1'b1;
      end
    end else begin
      st_next.acc     = cp;
      st_next.pending = st.pending - 2'd1;
      if (text_byte[7:6] != 2'b10) st_next.err = 1'b1;
      if (st.pending == 2'd1 && cp_bad) st_next.err = 1'b1;
    end
  end

  assign verdict = !st_next.err && (st_next.pending == 2'd0);

endmodule

// File: src/utf8sv_out_reg.sv
// ---------------------------------------------------------------------------
// utf8sv_out_reg
// result register holding one verdict until the sink takes it
// ---------------------------------------------------------------------------
module utf8sv_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic verdict,
  output logic free,
  output logic m_tvalid,
  input  logic m_tready,
  output logic result
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= verdict;
    end
  end

endmodule

// File: src/utf8sv_checker.sv
// ---------------------------------------------------------------------------
// utf8sv_checker
// port-level checks on the utf8 stream validator
// ---------------------------------------------------------------------------
`include "utf8_stream_validator_defines.svh"

module utf8sv_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled verdict holds
  `UTF8SV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata),
                      "verdict dropped or changed while stalled")

  // input stalls only behind a stalled verdict
  `UTF8SV_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready,
                     "input stalled without output back-pressure")

  // last-byte transfer yields a verdict
  `UTF8SV_ASSERT_NOW(a_verdict_due, s_tvalid && s_tready && s_tlast, ##2 m_tvalid,
                     "no verdict after last byte")

  // nothing pending right after reset
  `UTF8SV_ASSERT_NOW(a_reset_idle, $past(rst), !m_tvalid, "verdict valid after reset")

endmodule

bind utf8_stream_validator utf8sv_checker u_chk (.*);
